// ===== hdl/bol_pkg.sv =====
// bol_pkg: shared types and constants of the bounded ordered list
// action, status and cell command codes; no dependencies
`timescale 1ns / 1ps

package bol_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE_AT  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t           op;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== hdl/bounded_ordered_list.sv =====
// bounded_ordered_list: ordered list of up to DEPTH values, push/pop at ends, remove_at
// out_valid rises in the cycle after start; throughput one item per cycle, busy stays low
// DEPTH chained cells shift each entry from the position on at once, so no action stalls
// synchronous active-low reset clears the fill count and the result strobe only
// the receiver cannot stall: each result is shown for exactly one cycle
// depends on bol_pkg and bol_cell
`timescale 1ns / 1ps

module bounded_ordered_list import bol_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_action,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]         in_index,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  // width that holds both an index and the fill count for compares
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // fill count and result registers
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_removed_value_r, out_removed_value_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r;

  // chain wiring
  cell_cmd_t         cmd;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_tap  [DEPTH];
  logic [DATA_W-1:0] tap_or;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  fill_ext;
  logic [CNT_W-1:0]  last_pos;

  // the chain finishes an action in the cycle it arrives
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (fill_r == CNT_W'(DEPTH));
  assign is_empty = (fill_r == '0);
  assign idx_ext  = CMP_W'(in_index);
  assign fill_ext = CMP_W'(fill_r);
  assign last_pos = fill_r - CNT_W'(1);

  // action decoder: picks the cell operation, its position and the result status
  always_comb begin
    cmd.op         = CELL_HOLD;
    cmd.value      = in_value;
    pos            = '0;
    fill_nxt       = fill_r;
    out_status_nxt = ST_DONE;
    unique case (in_action)
      ACT_PUSH_BACK: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          // not full, so fill fits a position
          cmd.op   = CELL_INSERT;
          pos      = POS_W'(fill_r);
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          out_status_nxt = ST_FULL;
        end else begin
          cmd.op   = CELL_INSERT;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          cmd.op   = CELL_REMOVE;
          fill_nxt = last_pos;
        end
      end
      ACT_POP_BACK: begin
        if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          cmd.op   = CELL_REMOVE;
          pos      = POS_W'(last_pos);
          fill_nxt = last_pos;
        end
      end
      ACT_REMOVE_AT: begin
        // index past the end also covers the empty list
        if (idx_ext >= fill_ext) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          cmd.op   = CELL_REMOVE;
          pos      = idx_ext[POS_W-1:0];
          fill_nxt = last_pos;
        end
      end
      default: begin
        // unused action codes do nothing
        out_status_nxt = ST_DONE;
      end
    endcase
    if (!accept) begin
      cmd.op   = CELL_HOLD;
      fill_nxt = fill_r;
    end
  end

  // row of cells, each shifting toward its neighbors on insert and remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = in_value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      // the slot past the end reads as zero
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    bol_cell #(
      .POS_W (POS_W),
      .POS   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // only the addressed cell can drive a nonzero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  assign out_removed_value_nxt = (cmd.op == CELL_REMOVE) ? tap_or : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_removed_value_r <= out_removed_value_nxt;
      out_status_r        <= out_status_nxt;
      out_count_r         <= fill_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_value_r;
  assign out_status        = out_status_r;
  assign out_count         = out_count_r;

  // every accepted item yields a result strobe in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // fill count never exceeds the chain length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // a dropped push reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == CNT_W'(DEPTH)))
    else $error("full status with list not full");

  // a flagged pop or remove takes nothing out
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_removed_value == '0))
    else $error("flagged action returned a value");

  // the count moves only when an item was accepted
  a_fill_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> (fill_r == $past(fill_r)))
    else $error("fill changed without an item");

endmodule

// ===== hdl/bol_cell.sv =====
// bol_cell: one storage slot of the list chain
// depends on bol_pkg; neighbors feed left_data and right_data
`timescale 1ns / 1ps

module bol_cell import bol_pkg::*; #(
  parameter int POS_W = 4,
  parameter int POS   = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [POS_W-1:0]  pos,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] tap
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              at_pos;
  logic              after_pos;

  assign at_pos    = (pos == POS_W'(POS));
  assign after_pos = (pos < POS_W'(POS));

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (at_pos) begin
          data_nxt = cmd.value;
        end else if (after_pos) begin
          data_nxt = left_data;
        end
      end
      CELL_REMOVE: begin
        if (at_pos || after_pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  // only the addressed cell offers its value for removal
  assign tap  = at_pos ? data_r : '0;

endmodule
